// File: design/frahl_pkg.sv
package frahl_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int REG_COUNT_DEF = 4;

    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 9;
    localparam int RIDX_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 104;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL_D  = 3'd2,
        OP_DIV_D  = 3'd3,
        OP_SLT    = 3'd4,
        OP_MUL_HL = 3'd5,
        OP_DIV_HL = 3'd6,
        OP_LOAD   = 3'd7
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic mul_go;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_done;
    } dp_stat_t;

    // read-only data memory contents: word i holds floor(1.5 * i)
    function automatic logic [WORD_W-1:0] mem_word(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+1:0] triple;
        triple = {2'b00, addr} + {1'b0, addr, 1'b0};
        return WORD_W'(triple[ADDR_W+1:1]);
    endfunction

endpackage

// File: design/four_register_alu_hi_lo_executor_unit.sv
// Integer ALU with a small register file and a HI/LO pair, run one decoded
// instruction per input item.
// Input channel s_*: one item is one instruction (ADD, SUB, SLT, MUL, DIV,
// the HI/LO-only forms of MUL and DIV, LOAD). It is taken when s_tvalid and
// s_tready are both high at a rising edge.
// Output channel m_*: exactly one item per instruction, in order: status,
// which register was written and with what, and HI and LO afterwards.
// Sequencing: ADD, SUB, SLT, LOAD and both MUL forms pass from acceptance
// through an execute state to write-back, which loads the output register;
// a new instruction is accepted only after write-back. DIV starts the divider
// in execute and waits for it before write-back; the 32-step radix-2 divider
// produces one quotient bit per cycle. A divide by zero skips the divider
// and goes straight from execute to write-back.
// The controller works on one instruction at a time; the result sits in an
// output register, so a new instruction is accepted while it waits.
// When m_tready is low, the finished item holds in that register and the
// next instruction stops at write-back, so no register state changes until
// the item ahead has been taken.
// Reset (rst_n low, asynchronous): registers become 0, 10, 20, 30, HI and
// LO become 0, the output slot empties. The data memory is a fixed table.
module four_register_alu_hi_lo_executor_unit #(
    parameter int MEM_DEPTH = frahl_pkg::MEM_DEPTH_DEF,
    parameter int REG_COUNT = frahl_pkg::REG_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[2:0], dest_reg[4:3], src_a[6:5], src_b[8:7], mem_address[17:9]
    input  logic [frahl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], reg_written[2], written_index[4:3], written_value[36:5],
    // hi_value[68:37], lo_value[100:69]
    output logic [frahl_pkg::M_TDATA_W-1:0] m_tdata
);

    frahl_pkg::ctrl_cmd_t cmd;
    frahl_pkg::dp_stat_t  stat;

    // sequencing: accept, execute, divide wait, write-back
    frahl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // register file, HI/LO, multiplier, divider and output register
    frahl_dpath #(
        .MEM_DEPTH (MEM_DEPTH),
        .REG_COUNT (REG_COUNT)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

`ifndef ASSERT_OFF
    // one instruction at a time: no acceptance in the cycle after one
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a register write always comes with a clean status
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == frahl_pkg::ST_OK))
        else $error("register written with an error status");

    // index and value read zero when nothing was written
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[36:3] == '0))
        else $error("written index or value nonzero without a write");

    // a new item appears only out of write-back, never while the controller is idle
    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result presented while idle");
`endif

endmodule

// File: design/frahl_div.sv
module frahl_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [frahl_pkg::WORD_W-1:0] dividend,
    input  logic [frahl_pkg::WORD_W-1:0] divisor,
    output logic                         done,
    output logic [frahl_pkg::WORD_W-1:0] quotient,
    output logic [frahl_pkg::WORD_W-1:0] remainder
);

    localparam int W   = frahl_pkg::WORD_W;
    localparam int CW  = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          negq_reg;
    logic          negr_reg;
    logic [W:0]    trial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
        if (!trial[W])
        begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
            dvs_reg  <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
            negq_reg <= dividend[W-1] ^ divisor[W-1];
            negr_reg <= dividend[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // restore signs: quotient truncates, remainder follows the dividend
    assign quotient  = negq_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = negr_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign done      = done_reg;

endmodule

// File: design/frahl_dpath.sv
module frahl_dpath #(
    parameter int MEM_DEPTH = frahl_pkg::MEM_DEPTH_DEF,
    parameter int REG_COUNT = frahl_pkg::REG_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [frahl_pkg::S_TDATA_W-1:0] in_data,
    input  frahl_pkg::ctrl_cmd_t            cmd,
    output frahl_pkg::dp_stat_t             stat,
    output logic [frahl_pkg::M_TDATA_W-1:0] out_data
);

    localparam int W    = frahl_pkg::WORD_W;
    localparam int RIW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int RW   = frahl_pkg::RIDX_W;
    localparam int AW   = frahl_pkg::ADDR_W;

    logic [W-1:0]        rf_reg [REG_COUNT];
    logic [W-1:0]        hi_reg, hi_next;
    logic [W-1:0]        lo_reg, lo_next;
    frahl_pkg::alu_op_t  op_reg;
    logic [RW-1:0]       dst_reg;
    logic [AW-1:0]       addr_reg;
    logic [W-1:0]        a_reg, b_reg;
    logic [2*W-1:0]      prod_reg;
    logic [frahl_pkg::M_TDATA_W-1:0] out_reg;

    logic [RW-1:0]       in_src_a, in_src_b;
    logic [W-1:0]        a_val, b_val;
    logic signed [W-1:0] a_s, b_s;
    logic signed [2*W-1:0] prod;
    logic                div_done;
    logic [W-1:0]        div_q, div_r;

    frahl_pkg::status_t  res_status;
    logic                res_wr;
    logic [W-1:0]        res_val;

    assign in_src_a = in_data[6:5];
    assign in_src_b = in_data[8:7];

    // out-of-range register reads give zero
    always_comb
    begin
        a_val = '0;
        b_val = '0;
        if (32'(in_src_a) < REG_COUNT)
        begin
            a_val = rf_reg[in_src_a[RIW-1:0]];
        end
        if (32'(in_src_b) < REG_COUNT)
        begin
            b_val = rf_reg[in_src_b[RIW-1:0]];
        end
    end

    assign a_s  = a_reg;
    assign b_s  = b_reg;
    assign prod = a_s * b_s;

    frahl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign stat.is_mul   = op_reg inside {frahl_pkg::OP_MUL_D, frahl_pkg::OP_MUL_HL};
    assign stat.is_div   = op_reg inside {frahl_pkg::OP_DIV_D, frahl_pkg::OP_DIV_HL};
    assign stat.div_zero = (b_reg == '0);
    assign stat.div_done = div_done;

    // result of the held instruction, used at write-back
    always_comb
    begin
        res_status = frahl_pkg::ST_OK;
        res_wr     = 1'b0;
        res_val    = '0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        case (op_reg)
            frahl_pkg::OP_ADD:
            begin
                res_val = a_reg + b_reg;
                res_wr  = 1'b1;
            end
            frahl_pkg::OP_SUB:
            begin
                res_val = a_reg - b_reg;
                res_wr  = 1'b1;
            end
            frahl_pkg::OP_SLT:
            begin
                res_val = W'(a_s < b_s);
                res_wr  = 1'b1;
            end
            frahl_pkg::OP_MUL_D, frahl_pkg::OP_MUL_HL:
            begin
                hi_next = prod_reg[2*W-1:W];
                lo_next = prod_reg[W-1:0];
                res_val = prod_reg[W-1:0];
                res_wr  = (op_reg == frahl_pkg::OP_MUL_D);
            end
            frahl_pkg::OP_DIV_D, frahl_pkg::OP_DIV_HL:
            begin
                if (b_reg == '0)
                begin
                    res_status = frahl_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    hi_next = div_r;
                    lo_next = div_q;
                    res_val = div_q;
                    res_wr  = (op_reg == frahl_pkg::OP_DIV_D);
                end
            end
            frahl_pkg::OP_LOAD:
            begin
                if (32'(addr_reg) < MEM_DEPTH)
                begin
                    res_val = frahl_pkg::mem_word(addr_reg);
                    res_wr  = 1'b1;
                end
                else
                begin
                    res_status = frahl_pkg::ST_BAD_ADDR;
                end
            end
            default:
            begin
                res_wr = 1'b0;
            end
        endcase
        // writes to a register that does not exist are dropped
        if (32'(dst_reg) >= REG_COUNT)
        begin
            res_wr = 1'b0;
        end
        if (!res_wr)
        begin
            res_val = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= W'(10 * i);
            end
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (res_wr)
            begin
                rf_reg[dst_reg[RIW-1:0]] <= res_val;
            end
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= frahl_pkg::alu_op_t'(in_data[2:0]);
            dst_reg  <= in_data[4:3];
            addr_reg <= in_data[17:9];
            a_reg    <= a_val;
            b_reg    <= b_val;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= prod;
        end
        if (cmd.commit)
        begin
            out_reg <= {3'b000, lo_next, hi_next, res_val,
                        (res_wr ? dst_reg : 2'b00), res_wr, res_status};
        end
    end

    assign out_data = out_reg;

endmodule

// File: design/frahl_ctrl.sv
module frahl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  frahl_pkg::dp_stat_t  stat,
    output frahl_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_WB   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // the output slot frees up in the same cycle its item is taken
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_mul)
                begin
                    cmd.mul_go = 1'b1;
                    state_next = S_WB;
                end
                else if (stat.is_div && !stat.div_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
